// ===== hdl/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// stok_pkg - script tokenizer shared definitions
// Character codes, lexer modes, line counter sizing and the result record.
// ----------------------------------------------------------------------------
package stok_pkg;

   // Line counter width and the width of the reported line number
   localparam int LINE_BITS  = 20;
   localparam int LINE_OUT_W = 20;

   // Character codes
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Lexer modes, one-hot
   typedef enum logic [3:0] {
      MODE_BETWEEN = 4'b0001,
      MODE_COMMENT = 4'b0010,
      MODE_QUOTED  = 4'b0100,
      MODE_PLAIN   = 4'b1000
   } mode_type;

   // One result transfer
   typedef struct packed {
      logic [7:0]            token_byte;
      logic                  byte_valid;
      logic                  token_done;
      logic                  was_quoted;
      logic                  newline_before;
      logic [LINE_OUT_W-1:0] line_now;
   } result_type;

   // Fit the line counter into the reported field: zero-extend or truncate
   function automatic logic [LINE_OUT_W-1:0] line_out(input logic [LINE_BITS-1:0] v);
      logic [LINE_BITS+LINE_OUT_W-1:0] wide;
      wide = {{LINE_OUT_W{1'b0}}, v};
      return wide[LINE_OUT_W-1:0];
   endfunction

endpackage

// ===== hdl/stok_in_reg.sv =====
// ----------------------------------------------------------------------------
// stok_in_reg - input register
// Captures one script byte per transfer and holds it until the lexer advances.
// ----------------------------------------------------------------------------
module stok_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_byte,
   output logic       held_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff,  byte_in;
   logic       last_ff,  last_in;
   logic       take;

   assign in_ready = !valid_ff || advance;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      byte_in  = take ? in_byte : byte_ff;
      last_in  = take ? in_last : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;
   assign held_last  = last_ff;

endmodule

// ===== hdl/stok_lexer.sv =====
// ----------------------------------------------------------------------------
// stok_lexer - lexer state and per-byte decision
// Holds mode, line count and the skipped-newline flag; decides each byte.
// ----------------------------------------------------------------------------
module stok_lexer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           cur_byte,
   input  logic                 cur_last,
   output logic                 emit,
   output stok_pkg::result_type result
);

   stok_pkg::mode_type             mode_ff, mode_in;
   logic [stok_pkg::LINE_BITS-1:0] line_ff, line_in;
   logic                           saw_ff,  saw_in;
   logic                           is_ws, is_lf, line_full;
   logic [stok_pkg::LINE_BITS-1:0] line_next;

   assign is_ws     = cur_byte <= stok_pkg::CH_SPACE;
   assign is_lf     = cur_byte == stok_pkg::CH_LF;
   assign line_full = &line_ff;
   assign line_next = line_full ? line_ff : line_ff + 1'b1;

   always_comb begin
      mode_in                = mode_ff;
      line_in                = line_ff;
      saw_in                 = saw_ff;
      emit                   = 1'b0;
      result.token_byte      = 8'h00;
      result.byte_valid      = 1'b0;
      result.token_done      = 1'b0;
      result.was_quoted      = 1'b0;
      result.newline_before  = saw_ff;
      result.line_now        = stok_pkg::line_out(line_ff);

      unique case (mode_ff)
         stok_pkg::MODE_BETWEEN: begin
            if (is_ws) begin
               if (is_lf) begin
                  line_in = line_next;
                  saw_in  = 1'b1;
               end
            end else if (cur_byte == stok_pkg::CH_SEMI) begin
               mode_in = stok_pkg::MODE_COMMENT;
            end else if (cur_byte == stok_pkg::CH_QUOTE) begin
               result.was_quoted = 1'b1;
               mode_in           = stok_pkg::MODE_QUOTED;
               if (cur_last) begin
                  emit              = 1'b1;
                  result.token_done = 1'b1;
               end
            end else begin
               mode_in           = stok_pkg::MODE_PLAIN;
               emit              = 1'b1;
               result.token_byte = cur_byte;
               result.byte_valid = 1'b1;
               result.token_done = cur_last;
            end
         end
         stok_pkg::MODE_COMMENT: begin
            if (is_lf) begin
               line_in = line_next;
               saw_in  = 1'b1;
               mode_in = stok_pkg::MODE_BETWEEN;
            end
         end
         stok_pkg::MODE_QUOTED: begin
            result.was_quoted = 1'b1;
            if (cur_byte == stok_pkg::CH_QUOTE) begin
               emit              = 1'b1;
               result.token_done = 1'b1;
               saw_in            = 1'b0;
               mode_in           = stok_pkg::MODE_BETWEEN;
            end else begin
               if (cur_byte != stok_pkg::CH_CR) begin
                  emit              = 1'b1;
                  result.token_byte = cur_byte;
                  result.byte_valid = 1'b1;
               end
               if (is_lf) begin
                  line_in = line_next;
               end
               if (cur_last) begin
                  emit              = 1'b1;
                  result.token_done = 1'b1;
               end
            end
         end
         stok_pkg::MODE_PLAIN: begin
            emit = 1'b1;
            if (!is_ws && cur_byte != stok_pkg::CH_SEMI) begin
               result.token_byte = cur_byte;
               result.byte_valid = 1'b1;
               result.token_done = cur_last;
            end else begin
               // terminator ends the token, then counts as between tokens
               result.token_done = 1'b1;
               saw_in            = 1'b0;
               mode_in           = stok_pkg::MODE_BETWEEN;
               if (is_lf) begin
                  line_in = line_next;
                  saw_in  = 1'b1;
               end else if (cur_byte == stok_pkg::CH_SEMI) begin
                  mode_in = stok_pkg::MODE_COMMENT;
               end
            end
         end
         default: begin
            mode_in = stok_pkg::MODE_BETWEEN;
         end
      endcase

      // end of script: return to the start state
      if (cur_last) begin
         mode_in = stok_pkg::MODE_BETWEEN;
         line_in = {{(stok_pkg::LINE_BITS-1){1'b0}}, 1'b1};
         saw_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stok_pkg::MODE_BETWEEN;
         line_ff <= {{(stok_pkg::LINE_BITS-1){1'b0}}, 1'b1};
         saw_ff  <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         saw_ff  <= saw_in;
      end
   end

endmodule

// ===== hdl/stok_out_reg.sv =====
// ----------------------------------------------------------------------------
// stok_out_reg - result register
// Holds one result transfer until the consumer takes it.
// ----------------------------------------------------------------------------
module stok_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  stok_pkg::result_type load_data,
   input  logic                 out_ready,
   output logic                 out_valid,
   output logic                 out_free,
   output stok_pkg::result_type out_data
);

   logic                 valid_ff, valid_in;
   stok_pkg::result_type data_ff,  data_in;

   assign out_free = !valid_ff || out_ready;

   always_comb begin
      valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      data_in  = load ? load_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/script_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// script_tokenizer_top - script tokenizer
// A byte transfer passes from the input register through the lexer decision
// into the result register. Throughput: one byte per cycle, unless a byte with a
// result waits for room in the result register; the lexer decision is combinational.
// Reset: synchronous, active high; line count returns to one, lexer to
// between tokens, both registers empty.
// ----------------------------------------------------------------------------
module script_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   // script byte channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] script_byte
   input  logic        req_tlast,   // script_last
   // token result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] token_byte, [27:8] line_now, [31:28] zero
   output logic [2:0]  rsp_tuser,   // [0] byte_valid, [1] was_quoted, [2] newline_before
   output logic        rsp_tlast    // token_done
);

   logic                 held_valid;
   logic [7:0]           held_byte;
   logic                 held_last;
   logic                 emit;
   logic                 out_free;
   logic                 advance;
   stok_pkg::result_type lex_result;
   stok_pkg::result_type rsp_result;

   // Advance the held byte when its result has room, or when it makes no result
   assign advance = held_valid && (out_free || !emit);

   stok_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte),
      .held_last  (held_last)
   );

   // Lexer state moves only when the held byte is consumed
   stok_lexer u_lexer (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .cur_byte (held_byte),
      .cur_last (held_last),
      .emit     (emit),
      .result   (lex_result)
   );

   stok_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .load_data (lex_result),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_free  (out_free),
      .out_data  (rsp_result)
   );

   // Pack the result transfer
   assign rsp_tdata = {4'b0000, rsp_result.line_now, rsp_result.token_byte};
   assign rsp_tuser = {rsp_result.newline_before, rsp_result.was_quoted,
                       rsp_result.byte_valid};
   assign rsp_tlast = rsp_result.token_done;

endmodule
